// ----- hdl/heat_diffusion_1d_step_assert.svh -----
// assertion macros shared by the heat diffusion step rtl
`ifndef HEAT_DIFFUSION_1D_STEP_ASSERT_SVH
`define HEAT_DIFFUSION_1D_STEP_ASSERT_SVH
`ifndef ASSERT_OFF
// property checked at every clock edge outside reset
`define HD1D_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("heat diffusion step assertion failed");
// condition that must never be seen outside reset
`define HD1D_NEVER(name, expr) `HD1D_ASSERT(name, !(expr))
`else
`define HD1D_ASSERT(name, prop)
`define HD1D_NEVER(name, expr)
`endif
`endif

// ----- hdl/hd1d_pkg.sv -----
// types, constants and register codes of the heat diffusion step
package hd1d_pkg;

  // temperature format, signed q15.8
  localparam int TEMP_WIDTH = 24;
  // gain format, unsigned q0.16
  localparam int GAIN_WIDTH = 16;
  localparam int GAIN_FRAC  = 16;
  // right - 2*old + left needs two more bits than a temperature
  localparam int DIFF_WIDTH = TEMP_WIDTH + 2;
  // signed difference times gain with a zero sign bit added
  localparam int PROD_WIDTH = DIFF_WIDTH + GAIN_WIDTH + 1;
  // old value plus the scaled product, one bit of headroom
  localparam int SUM_WIDTH  = PROD_WIDTH - GAIN_FRAC + 1;

  // default queue depths
  localparam int JOB_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // configuration port
  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;

  typedef logic signed [TEMP_WIDTH-1:0] temp_t;
  typedef logic signed [DIFF_WIDTH-1:0] diff_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [SUM_WIDTH-1:0]  sum_t;
  typedef logic [GAIN_WIDTH-1:0]        gain_t;

  // register index, taken from paddr bit 2
  localparam logic REG_IDX_GAIN = 1'b0;
  localparam logic REG_IDX_HOLD = 1'b1;

  localparam gain_t GAIN_RESET = gain_t'(6554);
  localparam temp_t HOLD_RESET = temp_t'(25600);

  // saturation limits
  localparam temp_t TEMP_MAX = {1'b0, {(TEMP_WIDTH-1){1'b1}}};
  localparam temp_t TEMP_MIN = {1'b1, {(TEMP_WIDTH-1){1'b0}}};

  typedef struct packed {
    temp_t cell_temp;
    logic  last_cell;
  } in_item_t;

  typedef struct packed {
    temp_t new_temp;
    logic  last_out;
  } out_item_t;

  // one update: old value, stencil difference and end-of-pass mark
  typedef struct packed {
    temp_t old;
    diff_t diff;
    logic  last_out;
  } op_t;

  // work made by one input cell: one or two updates
  typedef struct packed {
    op_t  op0;
    op_t  op1;
    logic two_ops;
  } job_t;

  // position within the current pass
  typedef enum logic [1:0] {
    SEEN_NONE,
    SEEN_ONE,
    SEEN_MANY
  } seen_e;

endpackage

// ----- hdl/hd1d_fifo.sv -----
// small register queue used between and after the two halves
module hd1d_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [WIDTH-1:0]               wdata_i,
  input  logic                           pop_i,
  output logic [WIDTH-1:0]               rdata_o,
  output logic                           full_o,
  output logic                           empty_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hdl/hd1d_front.sv -----
// front half: tracks the stencil window and builds update jobs per cell
module hd1d_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  hd1d_pkg::in_item_t item_i,
  output logic              job_valid_o,
  output hd1d_pkg::job_t    job_o,
  output hd1d_pkg::seen_e   seen_o
);
  import hd1d_pkg::*;

  seen_e seen_q, seen_d;
  temp_t left_q, left_d;
  temp_t center_q, center_d;
  diff_t x_ext, c_ext, l_ext;

  assign seen_o = seen_q;

  assign x_ext = diff_t'(item_i.cell_temp);
  assign c_ext = diff_t'(center_q);
  assign l_ext = diff_t'(left_q);

  // window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= SEEN_NONE;
      left_q   <= '0;
      center_q <= '0;
    end else begin
      seen_q   <= seen_d;
      left_q   <= left_d;
      center_q <= center_d;
    end
  end

  // next window and the job for this cell
  always_comb begin
    seen_d      = seen_q;
    left_d      = left_q;
    center_d    = center_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    if (accept_i) begin
      unique case (seen_q)
        SEEN_NONE: begin
          if (item_i.last_cell) begin
            // single-cell bar, zero difference passes it through
            job_valid_o      = 1'b1;
            job_o.op0.old    = item_i.cell_temp;
            job_o.op0.diff   = '0;
            job_o.op0.last_out = 1'b1;
          end else begin
            center_d = item_i.cell_temp;
            seen_d   = SEEN_ONE;
          end
        end
        SEEN_ONE, SEEN_MANY: begin
          job_valid_o      = 1'b1;
          job_o.op0.old    = center_q;
          job_o.op0.last_out = 1'b0;
          // left end is one-sided
          if (seen_q == SEEN_ONE) begin
            job_o.op0.diff = x_ext - c_ext;
          end else begin
            job_o.op0.diff = x_ext - (c_ext <<< 1) + l_ext;
          end
          if (item_i.last_cell) begin
            // right end, one-sided, closes the pass
            job_o.two_ops      = 1'b1;
            job_o.op1.old      = item_i.cell_temp;
            job_o.op1.diff     = c_ext - x_ext;
            job_o.op1.last_out = 1'b1;
            seen_d   = SEEN_NONE;
            left_d   = '0;
            center_d = '0;
          end else begin
            left_d   = center_q;
            center_d = item_i.cell_temp;
            seen_d   = SEEN_MANY;
          end
        end
        default: begin
          seen_d = SEEN_NONE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/hd1d_back.sv -----
// back half: one update per cycle while jobs wait and results have room, multiply stage then add and saturate
module hd1d_back #(
  parameter int OUT_DEPTH = hd1d_pkg::OUT_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hd1d_pkg::job_t      job_i,
  input  logic                job_empty_i,
  output logic                job_pop_o,
  input  hd1d_pkg::gain_t     gain_i,
  input  hd1d_pkg::temp_t     hold_i,
  input  logic                pop_i,
  output logic                empty_o,
  output hd1d_pkg::out_item_t out_item_o
);
  import hd1d_pkg::*;

  localparam int CNT_W = $clog2(OUT_DEPTH+1);

  logic             sel_q, sel_d;
  logic             s1_valid_q;
  prod_t            prod_q;
  temp_t            old_q;
  logic             last_q;
  logic             pass_q;
  logic             issue;
  op_t              op;
  logic [CNT_W-1:0] out_count;
  logic             out_full;
  sum_t             sum;
  temp_t            sat_val;
  out_item_t        result;

  // room for the result already in flight plus this one
  assign issue = ~job_empty_i &
                 (((CNT_W+1)'(out_count) + (CNT_W+1)'(s1_valid_q)) <
                  (CNT_W+1)'(OUT_DEPTH));

  assign op        = sel_q ? job_i.op1 : job_i.op0;
  assign job_pop_o = issue & (sel_q | ~job_i.two_ops);

  // which update of the head job goes next
  always_comb begin
    sel_d = sel_q;
    if (issue) begin
      sel_d = ~sel_q & job_i.two_ops;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      sel_q      <= sel_d;
      s1_valid_q <= issue;
    end
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (issue) begin
      prod_q <= prod_t'(op.diff) * prod_t'($signed({1'b0, gain_i}));
      old_q  <= op.old;
      last_q <= op.last_out;
      pass_q <= (op.old == hold_i);
    end
  end

  // floor of the product, add and saturate, or pass a held cell unchanged
  always_comb begin
    sum = sum_t'(old_q) + sum_t'(prod_q >>> GAIN_FRAC);
    if (sum > sum_t'(TEMP_MAX)) begin
      sat_val = TEMP_MAX;
    end else if (sum < sum_t'(TEMP_MIN)) begin
      sat_val = TEMP_MIN;
    end else begin
      sat_val = temp_t'(sum);
    end
    result.new_temp = pass_q ? old_q : sat_val;
    result.last_out = last_q;
  end

  // result queue
  hd1d_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid_q),
    .wdata_i (result),
    .pop_i   (pop_i),
    .rdata_o (out_item_o),
    .full_o  (out_full),
    .empty_o (empty_o),
    .count_o (out_count)
  );

  // credit check keeps the result queue from overflowing
  `include "heat_diffusion_1d_step_assert.svh"
  `HD1D_NEVER(a_out_overflow, s1_valid_q && out_full)

endmodule

// ----- hdl/heat_diffusion_1d_step.sv -----
// top level of the one-step 1-d heat diffusion stencil
// Streams one bar of signed q15.8 cell temperatures per pass, one cell per
// cycle while the job queue is not full, and returns each cell updated by
// one explicit time step as old + gain*(right - 2*old + left), with one-sided
// ends, a single-cell bar unchanged and any cell equal to hold_value passed
// unchanged. Results lag the input by one cell: the first cell of a longer
// pass yields nothing, a middle cell yields its left neighbour, and the last
// cell yields two results (the last marked by last_out). The back half issues
// one update per cycle to its single multiplier while jobs wait and the result
// queue has room, so the two updates of each pass's last cell can slow the
// input. A result passes the job queue, multiply register and result queue
// before it can be popped. gain sits at address 0, hold_value at 4.
module heat_diffusion_1d_step #(
  parameter int JOB_DEPTH = hd1d_pkg::JOB_DEPTH,
  parameter int OUT_DEPTH = hd1d_pkg::OUT_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  hd1d_pkg::in_item_t                  in_item_i,
  output logic                                empty,
  input  logic                                pop,
  output hd1d_pkg::out_item_t                 out_item_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hd1d_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [hd1d_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [hd1d_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                pready
);
  import hd1d_pkg::*;

  gain_t gain_q;
  temp_t hold_q;
  logic  cfg_write;
  logic  accept;
  logic  job_valid;
  job_t  job_in, job_head;
  logic  job_empty, job_pop;
  logic  job_full;
  logic [$clog2(JOB_DEPTH+1)-1:0] job_count;
  seen_e seen;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      hold_q <= HOLD_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_IDX_GAIN) begin
        gain_q <= pwdata[GAIN_WIDTH-1:0];
      end else begin
        hold_q <= pwdata[TEMP_WIDTH-1:0];
      end
    end
  end

  // register read back
  always_comb begin
    if (paddr[2] == REG_IDX_GAIN) begin
      prdata = APB_DATA_WIDTH'(gain_q);
    end else begin
      prdata = APB_DATA_WIDTH'(hold_q);
    end
  end

  // input transaction
  assign full   = job_full;
  assign accept = push & ~full;

  hd1d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .job_valid_o (job_valid),
    .job_o       (job_in),
    .seen_o      (seen)
  );

  // queue between front and back
  hd1d_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .wdata_i (job_in),
    .pop_i   (job_pop),
    .rdata_o (job_head),
    .full_o  (job_full),
    .empty_o (job_empty),
    .count_o (job_count)
  );

  hd1d_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .gain_i      (gain_q),
    .hold_i      (hold_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

  `include "heat_diffusion_1d_step_assert.svh"
  `HD1D_NEVER(a_job_overflow, job_valid && job_full)
  `HD1D_ASSERT(a_last_makes_job, (accept && in_item_i.last_cell) |-> job_valid)
  `HD1D_ASSERT(a_pass_restart, (accept && in_item_i.last_cell) |=> (seen == SEEN_NONE))
  `HD1D_NEVER(a_pop_nothing, job_pop && (job_count == '0))

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the one-step 1-d heat diffusion stencil
`timescale 1ns / 1ps

module testbench;
  import hd1d_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_CELLS = 67;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [APB_ADDR_WIDTH-1:0] GAIN_ADDR = {REG_IDX_GAIN, 2'b00};
  localparam logic [APB_ADDR_WIDTH-1:0] HOLD_ADDR = {REG_IDX_HOLD, 2'b00};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t cell_in = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t cell_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [APB_DATA_WIDTH-1:0] pwdata = '0;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic pready;

  // cells waiting to be sent and updated temperatures still to arrive
  in_item_t cells_to_send[$];
  out_item_t due_temps[$];

  // shadow of the registers and the stencil window
  gain_t coef = GAIN_RESET;
  temp_t source_temp = HOLD_RESET;
  temp_t left_cell = '0;
  temp_t mid_cell = '0;
  seen_e pass_pos = SEEN_NONE;

  int send_idle_pct = 34;
  int recv_idle_pct = 34;
  int hold_off_req = 0;
  int hold_off_seen = 0;
  int hold_off_left = 0;
  int mismatches = 0;
  int cycles = 0;
  out_item_t want;

  heat_diffusion_1d_step dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (cell_in),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (cell_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // old + floor(gain * diff), saturated; fixed sources stay put
  function automatic temp_t relax(temp_t old, longint diff);
    longint total;
    if (old == source_temp) return old;
    total = longint'(old) + ((diff * longint'(coef)) >>> GAIN_FRAC);
    if (total > longint'(TEMP_MAX)) return TEMP_MAX;
    if (total < longint'(TEMP_MIN)) return TEMP_MIN;
    return temp_t'(total);
  endfunction

  // slide the stencil by one cell and queue the temperatures it releases
  function automatic void advance_stencil(in_item_t it);
    temp_t x;
    longint diff;
    x = it.cell_temp;
    if (pass_pos == SEEN_NONE) begin
      if (it.last_cell) begin
        due_temps.push_back('{new_temp: x, last_out: 1'b1});
      end else begin
        mid_cell = x;
        pass_pos = SEEN_ONE;
      end
      return;
    end
    if (pass_pos == SEEN_ONE) diff = longint'(x) - longint'(mid_cell);
    else diff = longint'(x) - 2 * longint'(mid_cell) + longint'(left_cell);
    due_temps.push_back('{new_temp: relax(mid_cell, diff), last_out: 1'b0});
    if (it.last_cell) begin
      diff = longint'(mid_cell) - longint'(x);
      due_temps.push_back('{new_temp: relax(x, diff), last_out: 1'b1});
      left_cell = '0;
      mid_cell = '0;
      pass_pos = SEEN_NONE;
    end else begin
      left_cell = mid_cell;
      mid_cell = x;
      pass_pos = SEEN_MANY;
    end
  endfunction

  // random cell, often close to its neighbor, sometimes extreme, a source, small or fully random
  function automatic temp_t pick_cell(temp_t prev);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return prev + temp_t'($urandom_range(0, 2047)) - temp_t'(1024);
      4: return TEMP_MAX;
      5: return TEMP_MIN;
      6: return source_temp;
      7: return temp_t'($urandom_range(0, 4095)) - temp_t'(2048);
      default: return temp_t'($urandom);
    endcase
  endfunction

  task automatic queue_cell(temp_t t, logic last);
    cells_to_send.push_back('{cell_temp: t, last_cell: last});
  endtask

  // one bar of random length, short bars most of the time
  task automatic queue_bar(output int len);
    temp_t t;
    case ($urandom_range(0, 9))
      0: len = 1;
      7, 8: len = $urandom_range(9, 20);
      9: len = $urandom_range(30, 60);
      default: len = $urandom_range(2, 8);
    endcase
    t = temp_t'($urandom);
    for (int i = 0; i < len; i++) begin
      t = pick_cell(t);
      queue_cell(t, i == len - 1);
    end
  endtask

  // register write through setup and access cycles
  task automatic write_reg(logic [APB_ADDR_WIDTH-1:0] addr, logic [APB_DATA_WIDTH-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == GAIN_ADDR) coef = data[GAIN_WIDTH-1:0];
    else source_temp = temp_t'(data[TEMP_WIDTH-1:0]);
  endtask

  task automatic set_regs(gain_t g, temp_t h);
    write_reg(GAIN_ADDR, {16'($urandom), g});
    write_reg(HOLD_ADDR, {8'($urandom), h});
  endtask

  // wait until every cell is in and every update is out, then let it drain
  task automatic settle();
    while (cells_to_send.size() != 0) @(posedge clk_i);
    while (due_temps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // sender: offers the oldest pending cell, with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        advance_stencil(cell_in);
        void'(cells_to_send.pop_front());
      end
      if (cells_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        push <= 1'b1;
        cell_in <= cells_to_send[0];
      end else begin
        push <= 1'b0;
        cell_in <= in_item_t'($urandom);
      end
    end
  end

  // receiver: checks each popped transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (due_temps.size() == 0) begin
          $display("%0t unexpected result: new_temp %0d last_out %0b", $time,
                   cell_out.new_temp, cell_out.last_out);
          mismatches++;
        end else begin
          want = due_temps.pop_front();
          if (cell_out.new_temp !== want.new_temp) begin
            $display("%0t new_temp mismatch: expected %0d actual %0d", $time,
                     want.new_temp, cell_out.new_temp);
            mismatches++;
          end
          if (cell_out.last_out !== want.last_out) begin
            $display("%0t last_out mismatch: expected %0b actual %0b", $time,
                     want.last_out, cell_out.last_out);
            mismatches++;
          end
        end
      end
      if (hold_off_seen != hold_off_req) begin
        hold_off_seen = hold_off_req;
        hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        pop <= 1'b0;
      end else begin
        pop <= $urandom_range(0, 99) >= recv_idle_pct;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[heat_diffusion_1d_step] ERROR");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int len;
    int filled;
    gain_t g;
    temp_t h;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: single-cell bars, a fixed source, a short bar
    queue_cell(temp_t'(500), 1'b1);
    queue_cell(TEMP_MIN, 1'b1);
    queue_cell(temp_t'(0), 1'b0);
    queue_cell(HOLD_RESET, 1'b0);
    queue_cell(temp_t'(0), 1'b1);
    queue_cell(temp_t'(256), 1'b0);
    queue_cell(temp_t'(512), 1'b0);
    queue_cell(temp_t'(1024), 1'b0);
    queue_cell(temp_t'(-768), 1'b1);
    settle();

    // full gain: alternating extremes drive the sum into saturation
    set_regs(gain_t'(16'hFFFF), temp_t'(0));
    queue_cell(TEMP_MAX, 1'b0);
    queue_cell(TEMP_MIN, 1'b0);
    queue_cell(TEMP_MAX, 1'b1);
    queue_cell(TEMP_MIN, 1'b0);
    queue_cell(TEMP_MAX, 1'b0);
    queue_cell(temp_t'(0), 1'b0);
    queue_cell(TEMP_MIN, 1'b1);
    settle();

    // zero gain: every cell passes through unchanged
    set_regs(gain_t'(0), TEMP_MAX);
    queue_cell(temp_t'(1000), 1'b0);
    queue_cell(temp_t'(-1000), 1'b1);
    settle();

    // random phases, each with its own register setting
    for (int p = 0; p < 8; p++) begin
      g = gain_t'($urandom);
      h = temp_t'($urandom);
      case (p)
        0: h = TEMP_MIN;
        1: begin g = gain_t'(1); h = TEMP_MAX; end
        3: g = gain_t'(16'hFFFF);
        4: g = gain_t'(0);
        7: begin g = GAIN_RESET; h = HOLD_RESET; end
        default: ;
      endcase
      set_regs(g, h);
      send_idle_pct = (p == 3) ? 0 : 34;
      recv_idle_pct = (p == 3) ? 0 : 34;
      filled = 0;
      while (filled < PHASE_CELLS) begin
        queue_bar(len);
        filled += len;
      end
      // receiver backs off while the sender keeps pushing
      if (p == 2 || p == 5) hold_off_req++;
      settle();
    end

    send_idle_pct = 34;
    recv_idle_pct = 34;
    settle();
    if (mismatches == 0 && due_temps.size() == 0) begin
      $display("[heat_diffusion_1d_step] OK");
    end else begin
      $display("[heat_diffusion_1d_step] ERROR");
    end
    $finish;
  end

endmodule

// ----- heat_diffusion_1d_step.f -----
+incdir+hdl
hdl/hd1d_pkg.sv
hdl/hd1d_fifo.sv
hdl/hd1d_front.sv
hdl/hd1d_back.sv
hdl/heat_diffusion_1d_step.sv
tb/testbench.sv
